// File: design/sdseq_pkg.sv
// shared types, codes and helpers of the sd card command sequencer
package sdseq_pkg;

  typedef enum logic [2:0] {
    REQ_INIT  = 3'd0,
    REQ_READ  = 3'd1,
    REQ_WRITE = 3'd2,
    REQ_CMD   = 3'd3,
    REQ_DATA  = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    RES_OK        = 4'd0,
    RES_DISK      = 4'd1,
    RES_TIMEOUT   = 4'd2,
    RES_CMD_CRC   = 4'd3,
    RES_CMD_CHECK = 4'd4,
    RES_DATA_CRC  = 4'd5,
    RES_FIFO      = 4'd6,
    RES_ALIGN     = 4'd7,
    RES_PARAM     = 4'd8,
    RES_NOT_READY = 4'd9
  } result_e;

  localparam logic [7:0] RSP_NONE = 8'h00;
  localparam logic [7:0] RSP_R1   = 8'h19;
  localparam logic [7:0] RSP_R1B  = 8'h1D;
  localparam logic [7:0] RSP_R2   = 8'h0A;
  localparam logic [7:0] RSP_R3   = 8'h01;
  localparam logic [7:0] CMD_DATA  = 8'h20;
  localparam logic [7:0] CMD_WRITE = 8'h40;

  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_ALL_CID   = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA  = 6'd3;
  localparam logic [5:0] CMD_SET_BUS   = 6'd6;
  localparam logic [5:0] CMD_SELECT    = 6'd7;
  localparam logic [5:0] CMD_IF_COND   = 6'd8;
  localparam logic [5:0] CMD_STOP      = 6'd12;
  localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;
  localparam logic [5:0] CMD_READ_ONE  = 6'd17;
  localparam logic [5:0] CMD_READ_MANY = 6'd18;
  localparam logic [5:0] CMD_WRITE_ONE = 6'd24;
  localparam logic [5:0] CMD_WRITE_MANY = 6'd25;
  localparam logic [5:0] CMD_OP_COND   = 6'd41;
  localparam logic [5:0] CMD_APP       = 6'd55;

  localparam logic [11:0] IF_COND_ECHO = 12'h1AA;
  localparam logic [31:0] OP_COND_ARG  = 32'h4030_0000;
  localparam logic [15:0] RCA_REQUEST  = 16'h1234;
  localparam logic [31:0] BLOCK_BYTES  = 32'd512;
  localparam logic [4:0]  ST_SUCCESS   = 5'd1;

  typedef struct packed {
    logic [31:0] response_word;
    logic [4:0]  status_bits;
    logic [63:0] buffer_address;
    logic [31:0] block_total;
    logic [31:0] start_block;
  } in_data_t;

  typedef struct packed {
    logic        clock_fast;
    logic [3:0]  result_code;
    logic [63:0] dma_address;
    logic [11:0] blocks_minus_one;
    logic [31:0] cmd_argument;
    logic [13:0] command_word;
  } out_data_t;

  function automatic logic [13:0] cmd_word(input logic [5:0] idx, input logic [7:0] rsp);
    return {idx, rsp};
  endfunction

  function automatic result_e cmd_code(input logic [4:0] st);
    result_e c;
    c = RES_DISK;
    if (st[2]) c = RES_TIMEOUT;
    if (st[3]) c = RES_CMD_CRC;
    if (st[4]) c = RES_CMD_CHECK;
    return c;
  endfunction

  function automatic result_e data_code(input logic [4:0] st);
    result_e c;
    c = RES_DISK;
    if (st[2]) c = RES_TIMEOUT;
    if (st[3]) c = RES_DATA_CRC;
    if (st[4]) c = RES_FIFO;
    return c;
  endfunction

endpackage

// File: design/sd_card_init_and_transfer_sequencer_top.sv
// sd card init and block transfer command sequencer, top level
//
// usage:
//   the slave stream carries requests and controller reports: tuser holds the
//   request type (start init, read, write, command report, data report), tdata
//   the block range, buffer address, status bits and response word.
//   the master stream carries at most one result per request: tuser is the
//   kind (issue command, done, failed), tdata the command word, argument,
//   block count, dma address, result code and the fast clock flag.
//   a transaction is registered at the input, decoded in one pass against the
//   sequencer state and written to the output register, where its result, if any,
//   is offered to the master stream. throughput is one transaction per cycle while
//   the master side takes results; the limit is the single pass of next-state
//   logic, whose longest path is the chunk advance (32-bit subtract and compare,
//   64-bit buffer add).
//   when the master side stalls, one result waits in the output register and
//   one more transaction waits in the input register; tready drops after that.
//   reset clears the phase to idle, drops the initialized and fast clock flags
//   and empties both registers.
module sd_card_init_and_transfer_sequencer_top #(
  parameter int MAX_CHUNK_BLOCKS = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // start_block, block_total, buffer_address, status_bits, response_word, zero fill
  input  logic [167:0] s_axis_tdata,
  // req_type
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // command_word, cmd_argument, blocks_minus_one, dma_address, result_code,
  // clock_fast, zero fill
  output logic [127:0] m_axis_tdata,
  // out_kind
  output logic [1:0]   m_axis_tuser
);

  localparam int CW = $clog2(MAX_CHUNK_BLOCKS + 1);

  typedef enum logic [4:0] {
    PH_IDLE  = 5'd0,
    PH_CMD0  = 5'd1,
    PH_CMD8  = 5'd2,
    PH_C55A  = 5'd3,
    PH_A41   = 5'd4,
    PH_CMD2  = 5'd5,
    PH_CMD3  = 5'd6,
    PH_CMD7  = 5'd7,
    PH_C55B  = 5'd8,
    PH_A6    = 5'd9,
    PH_CMD16 = 5'd10,
    PH_DCMD  = 5'd11,
    PH_DATA  = 5'd12,
    PH_CMD12 = 5'd13
  } phase_e;

  // input register
  logic                in_v_q;
  sdseq_pkg::in_data_t in_data_q;
  logic [2:0]          in_req_q;

  // output register
  logic                 out_v_q;
  sdseq_pkg::out_data_t out_data_q;
  sdseq_pkg::kind_e     out_kind_q;

  // sequencer state
  phase_e         phase_q, phase_d;
  logic           sd2_q, sd2_d;
  logic           blk_addr_q, blk_addr_d;
  logic           init_q, init_d;
  logic [15:0]    rca_q, rca_d;
  logic [31:0]    left_q, left_d;
  logic [31:0]    cpos_q, cpos_d;
  logic [63:0]    bpos_q, bpos_d;
  logic [CW-1:0]  chunk_q, chunk_d;
  logic           wr_q, wr_d;
  logic           fast_q, fast_d;

  logic adv;
  logic emit;
  logic do_chunk;
  sdseq_pkg::kind_e   o_kind;
  sdseq_pkg::result_e o_code;
  logic [13:0]   o_word;
  logic [31:0]   o_arg;
  logic [11:0]   o_bm1;
  logic [63:0]   o_dma;
  logic [CW-1:0] n_new;
  logic [5:0]    dcmd_idx;
  logic [4:0]    st;
  logic [31:0]   rsp;

  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = !in_v_q || adv;
  assign st            = in_data_q.status_bits;
  assign rsp           = in_data_q.response_word;

  always_comb begin
    phase_d    = phase_q;
    sd2_d      = sd2_q;
    blk_addr_d = blk_addr_q;
    init_d     = init_q;
    rca_d      = rca_q;
    left_d     = left_q;
    cpos_d     = cpos_q;
    bpos_d     = bpos_q;
    chunk_d    = chunk_q;
    wr_d       = wr_q;
    fast_d     = fast_q;
    emit       = 1'b0;
    do_chunk   = 1'b0;
    o_kind     = sdseq_pkg::KIND_CMD;
    o_code     = sdseq_pkg::RES_OK;
    o_word     = '0;
    o_arg      = '0;
    o_bm1      = '0;
    o_dma      = '0;
    n_new      = '0;
    dcmd_idx   = '0;

    case (in_req_q)
      sdseq_pkg::REQ_INIT: begin
        sd2_d      = 1'b0;
        blk_addr_d = 1'b0;
        init_d     = 1'b0;
        fast_d     = 1'b0;
        phase_d    = PH_CMD0;
        emit       = 1'b1;
        o_word     = sdseq_pkg::cmd_word(sdseq_pkg::CMD_GO_IDLE, sdseq_pkg::RSP_NONE);
      end
      sdseq_pkg::REQ_READ, sdseq_pkg::REQ_WRITE: begin
        emit = 1'b1;
        if (phase_q != PH_IDLE) begin
          o_kind = sdseq_pkg::KIND_FAIL;
          o_code = sdseq_pkg::RES_NOT_READY;
        end else if (in_data_q.block_total == '0) begin
          o_kind = sdseq_pkg::KIND_FAIL;
          o_code = sdseq_pkg::RES_PARAM;
        end else if (!init_q) begin
          o_kind = sdseq_pkg::KIND_FAIL;
          o_code = sdseq_pkg::RES_NOT_READY;
        end else begin
          wr_d     = (in_req_q == sdseq_pkg::REQ_WRITE);
          left_d   = in_data_q.block_total;
          cpos_d   = blk_addr_q ? in_data_q.start_block : (in_data_q.start_block << 9);
          bpos_d   = in_data_q.buffer_address;
          do_chunk = 1'b1;
        end
      end
      sdseq_pkg::REQ_DATA: begin
        if (st != '0 && phase_q == PH_DATA) begin
          if (st != sdseq_pkg::ST_SUCCESS) begin
            phase_d = PH_IDLE;
            emit    = 1'b1;
            o_kind  = sdseq_pkg::KIND_FAIL;
            o_code  = sdseq_pkg::data_code(st);
          end else if (chunk_q > CW'(1)) begin
            phase_d = PH_CMD12;
            emit    = 1'b1;
            o_word  = sdseq_pkg::cmd_word(sdseq_pkg::CMD_STOP, sdseq_pkg::RSP_R1B);
          end else begin
            do_chunk = 1'b1;
          end
        end
      end
      sdseq_pkg::REQ_CMD: begin
        if (st != '0 && phase_q != PH_IDLE && phase_q != PH_DATA) begin
          if (phase_q == PH_CMD0) begin
            sd2_d   = 1'b0;
            phase_d = PH_CMD8;
            emit    = 1'b1;
            o_word  = sdseq_pkg::cmd_word(sdseq_pkg::CMD_IF_COND, sdseq_pkg::RSP_R1);
            o_arg   = 32'(sdseq_pkg::IF_COND_ECHO);
          end else if (phase_q == PH_CMD8) begin
            emit = 1'b1;
            if (st == sdseq_pkg::ST_SUCCESS && rsp[11:0] != sdseq_pkg::IF_COND_ECHO) begin
              phase_d = PH_IDLE;
              o_kind  = sdseq_pkg::KIND_FAIL;
              o_code  = sdseq_pkg::RES_CMD_CHECK;
            end else begin
              if (st == sdseq_pkg::ST_SUCCESS) sd2_d = 1'b1;
              phase_d = PH_C55A;
              o_word  = sdseq_pkg::cmd_word(sdseq_pkg::CMD_APP, sdseq_pkg::RSP_R1);
            end
          end else if (st != sdseq_pkg::ST_SUCCESS) begin
            phase_d = PH_IDLE;
            emit    = 1'b1;
            o_kind  = sdseq_pkg::KIND_FAIL;
            o_code  = sdseq_pkg::cmd_code(st);
          end else begin
            case (phase_q)
              PH_C55A: begin
                phase_d = PH_A41;
                emit    = 1'b1;
                o_word  = sdseq_pkg::cmd_word(sdseq_pkg::CMD_OP_COND, sdseq_pkg::RSP_R3);
                o_arg   = sdseq_pkg::OP_COND_ARG;
              end
              PH_A41: begin
                emit = 1'b1;
                if (rsp[31]) begin
                  if (rsp[30]) blk_addr_d = 1'b1;
                  phase_d = PH_CMD2;
                  o_word  = sdseq_pkg::cmd_word(sdseq_pkg::CMD_ALL_CID, sdseq_pkg::RSP_R2);
                end else begin
                  phase_d = PH_C55A;
                  o_word  = sdseq_pkg::cmd_word(sdseq_pkg::CMD_APP, sdseq_pkg::RSP_R1);
                end
              end
              PH_CMD2: begin
                phase_d = PH_CMD3;
                emit    = 1'b1;
                o_word  = sdseq_pkg::cmd_word(sdseq_pkg::CMD_SEND_RCA, sdseq_pkg::RSP_R1B);
                o_arg   = {sdseq_pkg::RCA_REQUEST, 16'h0000};
              end
              PH_CMD3: begin
                rca_d   = rsp[31:16];
                phase_d = PH_CMD7;
                emit    = 1'b1;
                o_word  = sdseq_pkg::cmd_word(sdseq_pkg::CMD_SELECT, sdseq_pkg::RSP_R1B);
                o_arg   = {rsp[31:16], 16'h0000};
              end
              PH_CMD7: begin
                fast_d  = 1'b1;
                phase_d = PH_C55B;
                emit    = 1'b1;
                o_word  = sdseq_pkg::cmd_word(sdseq_pkg::CMD_APP, sdseq_pkg::RSP_R1);
                o_arg   = {rca_q, 16'h0000};
              end
              PH_C55B: begin
                phase_d = PH_A6;
                emit    = 1'b1;
                o_word  = sdseq_pkg::cmd_word(sdseq_pkg::CMD_SET_BUS, sdseq_pkg::RSP_R1);
              end
              PH_A6: begin
                phase_d = PH_CMD16;
                emit    = 1'b1;
                o_word  = sdseq_pkg::cmd_word(sdseq_pkg::CMD_BLOCKLEN, sdseq_pkg::RSP_R1);
                o_arg   = sdseq_pkg::BLOCK_BYTES;
              end
              PH_CMD16: begin
                init_d  = 1'b1;
                phase_d = PH_IDLE;
                emit    = 1'b1;
                o_kind  = sdseq_pkg::KIND_DONE;
              end
              PH_DCMD: begin
                phase_d = PH_DATA;
              end
              PH_CMD12: begin
                do_chunk = 1'b1;
              end
              default: begin
                phase_d = PH_IDLE;
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase

    // chunk advance after a finished chunk (done if none left), then chunk issue
    if (do_chunk && in_req_q != sdseq_pkg::REQ_READ && in_req_q != sdseq_pkg::REQ_WRITE) begin
      cpos_d = blk_addr_q ? (cpos_q + 32'(chunk_q)) : (cpos_q + (32'(chunk_q) << 9));
      bpos_d = bpos_q + (64'(chunk_q) << 9);
      left_d = (32'(chunk_q) > left_q) ? '0 : (left_q - 32'(chunk_q));
      if (left_d == '0) begin
        do_chunk = 1'b0;
        phase_d  = PH_IDLE;
        emit     = 1'b1;
        o_kind   = sdseq_pkg::KIND_DONE;
      end
    end

    if (do_chunk) begin
      emit = 1'b1;
      if (bpos_d[1:0] != 2'b00) begin
        phase_d = PH_IDLE;
        o_kind  = sdseq_pkg::KIND_FAIL;
        o_code  = sdseq_pkg::RES_ALIGN;
      end else begin
        n_new   = (left_d > 32'(MAX_CHUNK_BLOCKS)) ? CW'(MAX_CHUNK_BLOCKS) : left_d[CW-1:0];
        chunk_d = n_new;
        if (wr_d) begin
          dcmd_idx = (n_new == CW'(1)) ? sdseq_pkg::CMD_WRITE_ONE : sdseq_pkg::CMD_WRITE_MANY;
        end else begin
          dcmd_idx = (n_new == CW'(1)) ? sdseq_pkg::CMD_READ_ONE : sdseq_pkg::CMD_READ_MANY;
        end
        phase_d = PH_DCMD;
        o_word  = sdseq_pkg::cmd_word(dcmd_idx, sdseq_pkg::RSP_R1 | sdseq_pkg::CMD_DATA
                                      | (wr_d ? sdseq_pkg::CMD_WRITE : 8'h00));
        o_arg   = cpos_d;
        o_bm1   = 12'(32'(n_new) - 32'd1);
        o_dma   = bpos_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
      phase_q    <= PH_IDLE;
      sd2_q      <= 1'b0;
      blk_addr_q <= 1'b0;
      init_q     <= 1'b0;
      rca_q      <= '0;
      left_q     <= '0;
      cpos_q     <= '0;
      bpos_q     <= '0;
      chunk_q    <= '0;
      wr_q       <= 1'b0;
      fast_q     <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_v_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_v_q <= in_v_q && emit;
      end
      if (adv && in_v_q) begin
        phase_q    <= phase_d;
        sd2_q      <= sd2_d;
        blk_addr_q <= blk_addr_d;
        init_q     <= init_d;
        rca_q      <= rca_d;
        left_q     <= left_d;
        cpos_q     <= cpos_d;
        bpos_q     <= bpos_d;
        chunk_q    <= chunk_d;
        wr_q       <= wr_d;
        fast_q     <= fast_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata[164:0];
      in_req_q  <= s_axis_tuser;
    end
    if (adv && in_v_q && emit) begin
      out_kind_q                  <= o_kind;
      out_data_q.command_word     <= o_word;
      out_data_q.cmd_argument     <= o_arg;
      out_data_q.blocks_minus_one <= o_bm1;
      out_data_q.dma_address      <= o_dma;
      out_data_q.result_code      <= o_code;
      out_data_q.clock_fast       <= fast_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {1'b0, out_data_q};
  assign m_axis_tuser  = out_kind_q;

  // input side never stalls while the output slot can move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_v_q || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled with free output slot");

  // a waiting input transaction is kept while the output is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !adv) |=> in_v_q)
    else $error("input transaction lost during stall");

  // failures always carry a nonzero code, commands and completions never do
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> ((out_kind_q == sdseq_pkg::KIND_FAIL) == (out_data_q.result_code != 4'd0)))
    else $error("result code does not match result kind");

endmodule

// File: bench/tb_sd_card_init_and_transfer_sequencer_top.sv
// testbench for the sd card init and transfer sequencer: directed and random request streams
`timescale 1ns / 1ps

module tb_sd_card_init_and_transfer_sequencer_top;

  localparam int CHUNK_MAX    = 4096;
  localparam int RANDOM_ITEMS = 650;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_GO_IDLE, SQ_IF_COND, SQ_APP_A, SQ_OP_COND, SQ_ALL_CID, SQ_SEND_RCA,
    SQ_SELECT, SQ_APP_B, SQ_SET_BUS, SQ_BLOCKLEN, SQ_DATA_CMD, SQ_DATA_XFER, SQ_STOP
  } seq_phase_e;

  typedef struct {
    sdseq_pkg::kind_e     kind;
    sdseq_pkg::out_data_t data;
  } sd_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  sd_card_init_and_transfer_sequencer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted sequencer state
  seq_phase_e  seq_phase = SQ_IDLE;
  logic        card_v2 = 1'b0;
  logic        blk_addressing = 1'b0;
  logic        card_ready = 1'b0;
  logic [15:0] card_rca = '0;
  logic [31:0] xfer_left = '0;
  logic [31:0] xfer_card_pos = '0;
  logic [63:0] xfer_buf_pos = '0;
  logic [12:0] xfer_chunk = '0;
  logic        xfer_write = 1'b0;
  logic        bus_fast = 1'b0;

  sd_result_t pending_results[$];
  int fail_count = 0;
  int items_sent = 0;
  int effective_items = 0;
  int cmds_seen = 0;
  int dones_seen = 0;
  int fails_seen = 0;
  int stall_cycles = 0;
  bit calm = 1'b0;

  function automatic void queue_result(sdseq_pkg::kind_e k, logic [13:0] word,
                                       logic [31:0] arg, logic [11:0] bm1,
                                       logic [63:0] dma, sdseq_pkg::result_e code);
    sd_result_t r;
    r.kind = k;
    r.data.command_word = word;
    r.data.cmd_argument = arg;
    r.data.blocks_minus_one = bm1;
    r.data.dma_address = dma;
    r.data.result_code = code;
    r.data.clock_fast = bus_fast;
    pending_results.push_back(r);
  endfunction

  function automatic void issue_cmd(logic [5:0] idx, logic [7:0] rsp, logic [31:0] arg,
                                    seq_phase_e next);
    seq_phase = next;
    queue_result(sdseq_pkg::KIND_CMD, {idx, rsp}, arg, '0, '0, sdseq_pkg::RES_OK);
  endfunction

  function automatic void end_fail(sdseq_pkg::result_e code);
    seq_phase = SQ_IDLE;
    queue_result(sdseq_pkg::KIND_FAIL, '0, '0, '0, '0, code);
  endfunction

  function automatic sdseq_pkg::result_e decode_status(logic [4:0] st, bit on_data);
    sdseq_pkg::result_e c;
    c = sdseq_pkg::RES_DISK;
    if (st[2]) c = sdseq_pkg::RES_TIMEOUT;
    if (st[3]) c = on_data ? sdseq_pkg::RES_DATA_CRC : sdseq_pkg::RES_CMD_CRC;
    if (st[4]) c = on_data ? sdseq_pkg::RES_FIFO : sdseq_pkg::RES_CMD_CHECK;
    return c;
  endfunction

  function automatic void start_chunk();
    logic [12:0] n;
    logic [12:0] nm1;
    logic [5:0]  idx;
    if (xfer_buf_pos[1:0] != 2'b00) begin
      end_fail(sdseq_pkg::RES_ALIGN);
      return;
    end
    n = (xfer_left > CHUNK_MAX) ? 13'd4096 : xfer_left[12:0];
    nm1 = n - 13'd1;
    xfer_chunk = n;
    if (xfer_write) idx = (n == 13'd1) ? sdseq_pkg::CMD_WRITE_ONE : sdseq_pkg::CMD_WRITE_MANY;
    else idx = (n == 13'd1) ? sdseq_pkg::CMD_READ_ONE : sdseq_pkg::CMD_READ_MANY;
    seq_phase = SQ_DATA_CMD;
    queue_result(sdseq_pkg::KIND_CMD,
                 {idx, sdseq_pkg::RSP_R1 | sdseq_pkg::CMD_DATA
                       | (xfer_write ? sdseq_pkg::CMD_WRITE : sdseq_pkg::RSP_NONE)},
                 xfer_card_pos, nm1[11:0], xfer_buf_pos, sdseq_pkg::RES_OK);
  endfunction

  function automatic void next_chunk();
    logic [31:0] n32;
    n32 = {19'h0, xfer_chunk};
    xfer_card_pos = blk_addressing ? xfer_card_pos + n32 : xfer_card_pos + (n32 << 9);
    xfer_buf_pos = xfer_buf_pos + {32'h0, n32 << 9};
    xfer_left = (n32 > xfer_left) ? 32'h0 : xfer_left - n32;
    if (xfer_left == 32'h0) begin
      seq_phase = SQ_IDLE;
      queue_result(sdseq_pkg::KIND_DONE, '0, '0, '0, '0, sdseq_pkg::RES_OK);
    end else begin
      start_chunk();
    end
  endfunction

  function automatic void sequencer_step(sdseq_pkg::req_e rq, sdseq_pkg::in_data_t d);
    logic [31:0] rca_arg;
    rca_arg = {card_rca, 16'h0};
    if (rq == sdseq_pkg::REQ_INIT) begin
      card_v2 = 1'b0;
      blk_addressing = 1'b0;
      card_ready = 1'b0;
      bus_fast = 1'b0;
      issue_cmd(sdseq_pkg::CMD_GO_IDLE, sdseq_pkg::RSP_NONE, '0, SQ_GO_IDLE);
      return;
    end
    if (rq == sdseq_pkg::REQ_READ || rq == sdseq_pkg::REQ_WRITE) begin
      if (seq_phase != SQ_IDLE) begin
        queue_result(sdseq_pkg::KIND_FAIL, '0, '0, '0, '0, sdseq_pkg::RES_NOT_READY);
      end else if (d.block_total == 32'h0) begin
        end_fail(sdseq_pkg::RES_PARAM);
      end else if (!card_ready) begin
        end_fail(sdseq_pkg::RES_NOT_READY);
      end else begin
        xfer_write = (rq == sdseq_pkg::REQ_WRITE);
        xfer_left = d.block_total;
        xfer_card_pos = blk_addressing ? d.start_block : d.start_block << 9;
        xfer_buf_pos = d.buffer_address;
        start_chunk();
      end
      return;
    end
    if (d.status_bits == 5'd0) return;
    if (rq == sdseq_pkg::REQ_DATA) begin
      if (seq_phase != SQ_DATA_XFER) return;
      if (d.status_bits != sdseq_pkg::ST_SUCCESS) end_fail(decode_status(d.status_bits, 1'b1));
      else if (xfer_chunk > 13'd1) issue_cmd(sdseq_pkg::CMD_STOP, sdseq_pkg::RSP_R1B, '0, SQ_STOP);
      else next_chunk();
      return;
    end
    if (rq != sdseq_pkg::REQ_CMD || seq_phase == SQ_IDLE || seq_phase == SQ_DATA_XFER) return;
    if (seq_phase == SQ_GO_IDLE) begin
      card_v2 = 1'b0;
      issue_cmd(sdseq_pkg::CMD_IF_COND, sdseq_pkg::RSP_R1, {20'h0, sdseq_pkg::IF_COND_ECHO},
                SQ_IF_COND);
      return;
    end
    if (seq_phase == SQ_IF_COND) begin
      if (d.status_bits == sdseq_pkg::ST_SUCCESS) begin
        if (d.response_word[11:0] != sdseq_pkg::IF_COND_ECHO) begin
          end_fail(sdseq_pkg::RES_CMD_CHECK);
          return;
        end
        card_v2 = 1'b1;
      end
      issue_cmd(sdseq_pkg::CMD_APP, sdseq_pkg::RSP_R1, '0, SQ_APP_A);
      return;
    end
    if (d.status_bits != sdseq_pkg::ST_SUCCESS) begin
      end_fail(decode_status(d.status_bits, 1'b0));
      return;
    end
    case (seq_phase)
      SQ_APP_A: issue_cmd(sdseq_pkg::CMD_OP_COND, sdseq_pkg::RSP_R3, sdseq_pkg::OP_COND_ARG,
                          SQ_OP_COND);
      SQ_OP_COND: begin
        if (d.response_word[31]) begin
          if (d.response_word[30]) blk_addressing = 1'b1;
          issue_cmd(sdseq_pkg::CMD_ALL_CID, sdseq_pkg::RSP_R2, '0, SQ_ALL_CID);
        end else begin
          issue_cmd(sdseq_pkg::CMD_APP, sdseq_pkg::RSP_R1, '0, SQ_APP_A);
        end
      end
      SQ_ALL_CID: issue_cmd(sdseq_pkg::CMD_SEND_RCA, sdseq_pkg::RSP_R1B,
                            {sdseq_pkg::RCA_REQUEST, 16'h0}, SQ_SEND_RCA);
      SQ_SEND_RCA: begin
        card_rca = d.response_word[31:16];
        issue_cmd(sdseq_pkg::CMD_SELECT, sdseq_pkg::RSP_R1B, {card_rca, 16'h0}, SQ_SELECT);
      end
      SQ_SELECT: begin
        bus_fast = 1'b1;
        issue_cmd(sdseq_pkg::CMD_APP, sdseq_pkg::RSP_R1, rca_arg, SQ_APP_B);
      end
      SQ_APP_B: issue_cmd(sdseq_pkg::CMD_SET_BUS, sdseq_pkg::RSP_R1, '0, SQ_SET_BUS);
      SQ_SET_BUS: issue_cmd(sdseq_pkg::CMD_BLOCKLEN, sdseq_pkg::RSP_R1, sdseq_pkg::BLOCK_BYTES,
                            SQ_BLOCKLEN);
      SQ_BLOCKLEN: begin
        card_ready = 1'b1;
        seq_phase = SQ_IDLE;
        queue_result(sdseq_pkg::KIND_DONE, '0, '0, '0, '0, sdseq_pkg::RES_OK);
      end
      SQ_DATA_CMD: seq_phase = SQ_DATA_XFER;
      SQ_STOP: next_chunk();
      default: seq_phase = SQ_IDLE;
    endcase
  endfunction

  task automatic send_item(sdseq_pkg::req_e rq, sdseq_pkg::in_data_t d);
    int         queued;
    seq_phase_e was;
    while (!calm && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, d};
    s_axis_tuser <= rq;
    do @(posedge clk_i); while (!s_axis_tready);
    queued = pending_results.size();
    was = seq_phase;
    sequencer_step(rq, d);
    items_sent++;
    if (pending_results.size() != queued || seq_phase != was) effective_items++;
  endtask

  task automatic send_request(sdseq_pkg::req_e rq, logic [31:0] first, logic [31:0] count,
                              logic [63:0] buf_addr);
    sdseq_pkg::in_data_t d;
    d.start_block = first;
    d.block_total = count;
    d.buffer_address = buf_addr;
    d.status_bits = 5'($urandom());
    d.response_word = $urandom();
    send_item(rq, d);
  endtask

  task automatic send_report(sdseq_pkg::req_e rq, logic [4:0] st, logic [31:0] rsp);
    sdseq_pkg::in_data_t d;
    d.start_block = $urandom();
    d.block_total = $urandom();
    d.buffer_address = {$urandom(), $urandom()};
    d.status_bits = st;
    d.response_word = rsp;
    send_item(rq, d);
  endtask

  task automatic random_transfer();
    int          pick;
    logic [31:0] count;
    logic [63:0] buf_addr;
    pick = $urandom_range(99);
    if (pick < 70) count = $urandom_range(1, 4);
    else if (pick < 85) count = $urandom_range(5, 64);
    else if (pick < 93) count = $urandom_range(4090, 8200);
    else if (pick < 97) count = $urandom();
    else count = 32'h0;
    buf_addr = {$urandom(), $urandom()};
    if ($urandom_range(19) != 0) buf_addr[1:0] = 2'b00;
    send_request($urandom_range(1) ? sdseq_pkg::REQ_WRITE : sdseq_pkg::REQ_READ, $urandom(),
                 count, buf_addr);
  endtask

  // the report the controller would give for the command now in flight
  task automatic expected_report();
    int          pick;
    logic [31:0] rsp;
    logic [4:0]  st;
    pick = $urandom_range(9);
    rsp = $urandom();
    case (seq_phase)
      SQ_GO_IDLE: begin
        st = 5'($urandom_range(1, 31));
        send_report(sdseq_pkg::REQ_CMD, st, rsp);
      end
      SQ_IF_COND: begin
        if (pick < 7) begin
          rsp[11:0] = sdseq_pkg::IF_COND_ECHO;
          send_report(sdseq_pkg::REQ_CMD, sdseq_pkg::ST_SUCCESS, rsp);
        end else if (pick < 9) begin
          st = 5'($urandom_range(2, 31));
          send_report(sdseq_pkg::REQ_CMD, st, rsp);
        end else begin
          send_report(sdseq_pkg::REQ_CMD, sdseq_pkg::ST_SUCCESS, rsp);
        end
      end
      SQ_OP_COND: begin
        rsp[31] = (pick < 6);
        send_report(sdseq_pkg::REQ_CMD, sdseq_pkg::ST_SUCCESS, rsp);
      end
      SQ_DATA_XFER: send_report(sdseq_pkg::REQ_DATA, sdseq_pkg::ST_SUCCESS, rsp);
      default: send_report(sdseq_pkg::REQ_CMD, sdseq_pkg::ST_SUCCESS, rsp);
    endcase
  endtask

  task automatic random_step();
    int              pick;
    logic [4:0]      st;
    sdseq_pkg::req_e right_kind;
    sdseq_pkg::req_e wrong_kind;
    pick = $urandom_range(99);
    right_kind = (seq_phase == SQ_DATA_XFER) ? sdseq_pkg::REQ_DATA : sdseq_pkg::REQ_CMD;
    wrong_kind = (seq_phase == SQ_DATA_XFER) ? sdseq_pkg::REQ_CMD : sdseq_pkg::REQ_DATA;
    if (seq_phase == SQ_IDLE) begin
      if (!card_ready || pick < 4) begin
        send_request(sdseq_pkg::REQ_INIT, $urandom(), $urandom(), {$urandom(), $urandom()});
      end else if (pick < 8) begin
        st = 5'($urandom());
        send_report(pick[0] ? sdseq_pkg::REQ_CMD : sdseq_pkg::REQ_DATA, st, $urandom());
      end else begin
        random_transfer();
      end
    end else if (pick < 85) begin
      expected_report();
    end else begin
      case ($urandom_range(4))
        0: begin
          st = 5'($urandom_range(2, 31));
          send_report(right_kind, st, $urandom());
        end
        1: begin
          st = 5'($urandom_range(1, 31));
          send_report(wrong_kind, st, $urandom());
        end
        2: send_report(right_kind, 5'd0, $urandom());
        3: random_transfer();
        default: send_request(sdseq_pkg::REQ_INIT, $urandom(), $urandom(),
                              {$urandom(), $urandom()});
      endcase
    end
  endtask

  task automatic test_before_init();
    send_request(sdseq_pkg::REQ_READ, 32'h0, 32'h0, 64'h0);
    send_request(sdseq_pkg::REQ_WRITE, 32'hFFFF_FFFF, 32'h1, 64'h0);
  endtask

  task automatic test_failed_init();
    send_request(sdseq_pkg::REQ_INIT, 32'h0, 32'h0, 64'h0);
    send_report(sdseq_pkg::REQ_CMD, 5'h1F, 32'hFFFF_FFFF);
    send_report(sdseq_pkg::REQ_CMD, sdseq_pkg::ST_SUCCESS, 32'h0000_01AB);
  endtask

  // version 1 card, byte addressing, one busy answer to the op cond loop
  task automatic test_bring_up();
    send_request(sdseq_pkg::REQ_INIT, $urandom(), $urandom(), {$urandom(), $urandom()});
    send_report(sdseq_pkg::REQ_CMD, sdseq_pkg::ST_SUCCESS, $urandom());
    send_report(sdseq_pkg::REQ_CMD, 5'h05, 32'h0000_01AA);
    send_report(sdseq_pkg::REQ_CMD, sdseq_pkg::ST_SUCCESS, $urandom());
    send_report(sdseq_pkg::REQ_CMD, sdseq_pkg::ST_SUCCESS, 32'h7FFF_FFFF);
    send_report(sdseq_pkg::REQ_CMD, sdseq_pkg::ST_SUCCESS, $urandom());
    send_report(sdseq_pkg::REQ_CMD, sdseq_pkg::ST_SUCCESS, 32'h80FF_8000);
    send_report(sdseq_pkg::REQ_CMD, sdseq_pkg::ST_SUCCESS, $urandom());
    send_report(sdseq_pkg::REQ_CMD, sdseq_pkg::ST_SUCCESS, 32'hBEEF_0000);
    send_request(sdseq_pkg::REQ_READ, 32'h10, 32'h2, 64'h1000);
    send_report(sdseq_pkg::REQ_CMD, sdseq_pkg::ST_SUCCESS, $urandom());
    send_report(sdseq_pkg::REQ_CMD, sdseq_pkg::ST_SUCCESS, $urandom());
    send_report(sdseq_pkg::REQ_CMD, sdseq_pkg::ST_SUCCESS, $urandom());
    send_report(sdseq_pkg::REQ_CMD, sdseq_pkg::ST_SUCCESS, $urandom());
  endtask

  // largest request: full chunk, stop command, second chunk issued, data error ignored
  task automatic test_chunked_write();
    send_request(sdseq_pkg::REQ_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFC);
    send_report(sdseq_pkg::REQ_CMD, sdseq_pkg::ST_SUCCESS, $urandom());
    send_report(sdseq_pkg::REQ_DATA, sdseq_pkg::ST_SUCCESS, $urandom());
    send_report(sdseq_pkg::REQ_CMD, sdseq_pkg::ST_SUCCESS, $urandom());
    send_report(sdseq_pkg::REQ_DATA, 5'h1E, $urandom());
    send_request(sdseq_pkg::REQ_READ, 32'h0, 32'h1, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_random_traffic();
    int first;
    first = effective_items;
    while (effective_items - first < RANDOM_ITEMS) begin
      calm = (effective_items - first >= 250) && (effective_items - first < 400);
      random_step();
    end
    calm = 1'b0;
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 19);
  end

  function automatic void compare_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t mismatch %s: expected %h, actual %h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    sd_result_t           want;
    sdseq_pkg::out_data_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[126:0];
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t unexpected transaction: expected none, actual kind %0d data %h",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        compare_field("kind", 64'(want.kind), 64'(m_axis_tuser));
        compare_field("command_word", 64'(want.data.command_word),
                      64'(got.command_word));
        compare_field("cmd_argument", 64'(want.data.cmd_argument),
                      64'(got.cmd_argument));
        compare_field("blocks_minus_one", 64'(want.data.blocks_minus_one),
                      64'(got.blocks_minus_one));
        compare_field("dma_address", want.data.dma_address, got.dma_address);
        compare_field("result_code", 64'(want.data.result_code),
                      64'(got.result_code));
        compare_field("clock_fast", 64'(want.data.clock_fast), 64'(got.clock_fast));
        case (want.kind)
          sdseq_pkg::KIND_CMD: cmds_seen++;
          sdseq_pkg::KIND_DONE: dones_seen++;
          default: fails_seen++;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL sd_card_init_and_transfer_sequencer_top");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_before_init();
    test_failed_init();
    test_bring_up();
    test_chunked_write();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("run covered %0d request and report transactions (%0d with effect)",
             items_sent, effective_items);
    $display("results checked: %0d commands, %0d completions, %0d failures",
             cmds_seen, dones_seen, fails_seen);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASS sd_card_init_and_transfer_sequencer_top");
    end else begin
      $display("FAIL sd_card_init_and_transfer_sequencer_top");
    end
    $finish;
  end

endmodule
